### sv/lattice_site_to_rank_and_index_top_macros.svh
// Assertion macros used by the lattice site locator checker
`ifndef LATTICE_SITE_TO_RANK_AND_INDEX_TOP_MACROS_SVH
`define LATTICE_SITE_TO_RANK_AND_INDEX_TOP_MACROS_SVH

// Consequent must hold on the cycle after the antecedent
`define LSRI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold on the same cycle as the antecedent
`define LSRI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### sv/lsri_pkg.sv
// Shared widths, register codes and helper functions of the lattice site locator
package lsri_pkg;

    localparam int COORD_W    = 17;
    localparam int RANK_W     = 16;
    localparam int SITE_W     = 24;
    localparam int EXT_W      = 7;
    localparam int PROC_W     = 5;
    localparam int TOT_W      = 11;
    localparam int Y_W        = 6;
    localparam int P_W        = 4;
    localparam int CB_W       = 3;
    localparam int POS_W      = 12;
    localparam int CELL_W     = 18;
    localparam int TAB_W      = 12;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 7;

    // Register index codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXT_T   = 4'd0,
        REG_EXT_X   = 4'd1,
        REG_EXT_Y   = 4'd2,
        REG_EXT_Z   = 4'd3,
        REG_PROCS_T = 4'd4,
        REG_PROCS_X = 4'd5,
        REG_PROCS_Y = 4'd6,
        REG_PROCS_Z = 4'd7
    } cfg_reg_t;

    // v / 3 for v below 128, by reciprocal multiply
    function automatic logic [5:0] div3(input logic [6:0] v);
        logic [12:0] m;
        m = 13'(v) * 13'd43;
        return m[12:7];
    endfunction

    // Four restoring steps of a remainder computation
    function automatic logic [TOT_W-1:0] mod_step4(
        input logic [TOT_W-1:0] rem,
        input logic [3:0]       bits,
        input logic [TOT_W-1:0] tot
    );
        logic [TOT_W:0]   t;
        logic [TOT_W-1:0] r;
        r = rem;
        for (int i = 3; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= {1'b0, tot})
                t = t - {1'b0, tot};
            r = t[TOT_W-1:0];
        end
        return r;
    endfunction

    // Split g into quotient and remainder by ext, quotient below 16
    function automatic logic [P_W+Y_W-1:0] div_ext(
        input logic [TOT_W-1:0] g,
        input logic [EXT_W-1:0] ext
    );
        logic [TOT_W-1:0] r;
        logic [TOT_W-1:0] sh;
        logic [P_W-1:0]   q;
        r = g;
        q = '0;
        for (int i = P_W - 1; i >= 0; i--) begin
            sh = TOT_W'(ext) << i;
            if (r >= sh) begin
                r    = r - sh;
                q[i] = 1'b1;
            end
        end
        return {q, r[Y_W-1:0]};
    endfunction

    // Quotient and remainder of two small values, divisor nonzero
    function automatic logic [2*PROC_W-1:0] div_small(
        input logic [PROC_W-1:0] v,
        input logic [PROC_W-1:0] dv
    );
        logic [2*PROC_W-1:0] r;
        logic [2*PROC_W-1:0] sh;
        logic [PROC_W-1:0]   q;
        r = (2*PROC_W)'(v);
        q = '0;
        for (int i = PROC_W - 1; i >= 0; i--) begin
            sh = (2*PROC_W)'(dv) << i;
            if (r >= sh) begin
                r    = r - sh;
                q[i] = 1'b1;
            end
        end
        return {q, r[PROC_W-1:0]};
    endfunction

endpackage

### sv/lsri_ram.sv
// Generic single-write, single-read RAM with registered read data
module lsri_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
)(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/lattice_site_to_rank_and_index_top.sv
// Lattice site locator: owner rank and cache-blocked even-odd local index
//
// Usage:
//   Input channel (in_valid / in_stall) carries one signed 4-D global
//   coordinate per item; output channel (out_valid / out_stall) returns the
//   owning process rank and the local site index for that item, in order.
//   Configuration port (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   extents (indexes 0..3) and process grid sizes (4..7); cfg_ready is
//   always high. Write only while no item is in flight.
//   One item per cycle is accepted back to back when neither a rebuild nor
//   a held result stalls the input. The 17-bit periodic wrap is done four
//   remainder bits per stage over five stages.
//   After reset and after every register write the same-parity rank table
//   is rebuilt: a settle phase, then a walk over local_extent_t * cb_x *
//   cb_y * cb_z table positions, with in_stall held high throughout.
//   When out_stall holds a waiting result, the whole pipeline freezes and
//   in_stall rises; nothing is lost or repeated.
module lattice_site_to_rank_and_index_top
    import lsri_pkg::*;
#(
    parameter int PROC_BLOCK_T     = 1,
    parameter int PROC_BLOCK_X     = 1,
    parameter int PROC_BLOCK_Y     = 1,
    parameter int PROC_BLOCK_Z     = 1,
    parameter int MAX_EXTENT       = 64,
    parameter int RANK_TABLE_DEPTH = 4096
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] coord_t,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [RANK_W-1:0]         owner_rank,
    output logic [SITE_W-1:0]         local_site
);

    localparam int ADDR_W     = $clog2(RANK_TABLE_DEPTH);
    localparam int DIV_STAGES = 5;
    localparam int LAST       = 13;
    localparam int PB [4]     = '{PROC_BLOCK_T, PROC_BLOCK_X, PROC_BLOCK_Y, PROC_BLOCK_Z};
    localparam logic [RANK_W-1:0] BLK_VOL =
        RANK_W'(PROC_BLOCK_T * PROC_BLOCK_X * PROC_BLOCK_Y * PROC_BLOCK_Z);
    localparam logic [EXT_W-1:0] EXT_MAX   = EXT_W'(MAX_EXTENT);
    localparam logic [POS_W:0]   DEPTH_LIM = (POS_W + 1)'(RANK_TABLE_DEPTH);

    typedef enum logic [1:0] {
        ST_SETTLE,
        ST_WALK,
        ST_RUN
    } state_t;

    // configuration registers as written
    logic [EXT_W-1:0]  ext_raw_reg   [4];
    logic [PROC_W-1:0] procs_raw_reg [4];

    // derived configuration, first level
    logic [EXT_W-1:0]  ext_cl    [4];
    logic [PROC_W-1:0] procs_cl  [4];
    logic [2*PROC_W-1:0] nblk_div [4];
    logic [EXT_W-1:0]  ext_reg   [4];
    logic [TOT_W-1:0]  tot_reg   [4];
    logic [PROC_W-1:0] nblk_reg  [4];
    logic [CB_W-1:0]   cb_reg    [1:3];
    logic [EXT_W-1:0]  cbc_reg   [1:3];
    logic [13:0]       e01_reg;
    logic [13:0]       e23_reg;
    logic [6:0]        cbp_reg;
    // derived configuration, second level
    logic [SITE_W-1:0] vol_half_reg;
    logic [12:0]       cb_vol_reg;
    logic [27:0]       vol_full;

    // control
    state_t            state_reg;
    logic [1:0]        settle_reg;
    logic [Y_W-1:0]    wa_reg;
    logic [1:0]        wb_reg;
    logic [1:0]        wc_reg;
    logic [1:0]        we_reg;
    logic [POS_W-1:0]  wpos_reg;
    logic [TAB_W-1:0]  even_reg;
    logic [TAB_W-1:0]  odd_reg;
    logic              walk_par;
    logic              walk_last;
    logic              cfg_wr;
    logic              adv;
    logic              run;
    logic              vld_reg [0:LAST];

    // pipeline payload
    logic signed [COORD_W-1:0] coord_in [4];
    logic [TOT_W-1:0]  div_rem_reg [0:DIV_STAGES][4];
    logic [19:0]       div_dvd_reg [0:DIV_STAGES][4];
    logic              div_neg_reg [0:DIV_STAGES][4];
    logic [TOT_W-1:0]  s6_w_reg    [4];
    logic [P_W-1:0]    s7_p_reg    [4];
    logic [Y_W-1:0]    s7_y_reg    [4];
    logic [Y_W-1:0]    s8_yq_next  [1:3];
    logic [1:0]        s8_yr_next  [1:3];
    logic [2*PROC_W-1:0] s8_div_next [4];
    logic [Y_W-1:0]    s8_yq_reg   [1:3];
    logic [1:0]        s8_yr_reg   [1:3];
    logic [Y_W-1:0]    s8_y0_reg;
    logic [P_W-1:0]    s8_nb_reg   [4];
    logic [P_W-1:0]    s8_np_reg   [4];
    logic              s8_par_reg;
    logic [7:0]        s9_posa_reg;
    logic [11:0]       s9_cella_reg;
    logic [RANK_W-1:0] s9_br_reg;
    logic [RANK_W-1:0] s9_ir_reg;
    logic [1:0]        s9_yr2_reg;
    logic [1:0]        s9_yr3_reg;
    logic [Y_W-1:0]    s9_yq3_reg;
    logic [P_W-1:0]    s9_nb2_reg;
    logic [P_W-1:0]    s9_nb3_reg;
    logic [P_W-1:0]    s9_np2_reg;
    logic [P_W-1:0]    s9_np3_reg;
    logic              s9_par_reg;
    logic [9:0]        s10_posb_reg;
    logic [CELL_W-1:0] s10_cell_reg;
    logic [RANK_W-1:0] s10_br_reg;
    logic [RANK_W-1:0] s10_ir_reg;
    logic [1:0]        s10_yr3_reg;
    logic [P_W-1:0]    s10_nb3_reg;
    logic [P_W-1:0]    s10_np3_reg;
    logic              s10_par_reg;
    logic [POS_W-1:0]  s11_pos_reg;
    logic [CELL_W-1:0] s11_cell_reg;
    logic [RANK_W-1:0] s11_br_reg;
    logic [RANK_W-1:0] s11_ir_reg;
    logic              s11_par_reg;
    logic              s12_inr_reg;
    logic [24:0]       s12_cbp_reg;
    logic [RANK_W-1:0] s12_rank_reg;
    logic              s12_par_reg;
    logic [TAB_W-1:0]  tab_rd;
    logic [TAB_W-1:0]  tab_sel;
    logic [RANK_W-1:0] rank_out_reg;
    logic [SITE_W-1:0] site_out_reg;

    assign coord_in[0] = coord_t;
    assign coord_in[1] = coord_x;
    assign coord_in[2] = coord_y;
    assign coord_in[3] = coord_z;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;
    assign run       = (state_reg == ST_RUN);
    assign adv       = !vld_reg[LAST] || !out_stall;
    assign in_stall  = !(adv && run);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int d = 0; d < 4; d++) begin
                ext_raw_reg[d]   <= EXT_W'(8);
                procs_raw_reg[d] <= PROC_W'(1);
            end
        end else if (cfg_wr) begin
            unique case (cfg_reg_t'(cfg_index)) inside
                REG_EXT_T, REG_EXT_X, REG_EXT_Y, REG_EXT_Z:
                    ext_raw_reg[cfg_index[1:0]] <= cfg_data;
                REG_PROCS_T, REG_PROCS_X, REG_PROCS_Y, REG_PROCS_Z:
                    procs_raw_reg[cfg_index[1:0]] <= cfg_data[PROC_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp raw register values into range
    always_comb
    begin
        for (int d = 0; d < 4; d++) begin
            if (ext_raw_reg[d] == '0)
                ext_cl[d] = EXT_W'(1);
            else if (ext_raw_reg[d] > EXT_MAX)
                ext_cl[d] = EXT_MAX;
            else
                ext_cl[d] = ext_raw_reg[d];
            if (procs_raw_reg[d] == '0)
                procs_cl[d] = PROC_W'(1);
            else if (procs_raw_reg[d] > PROC_W'(16))
                procs_cl[d] = PROC_W'(16);
            else
                procs_cl[d] = procs_raw_reg[d];
            nblk_div[d] = div_small(procs_cl[d], PROC_W'(PB[d]));
        end
    end

    // derived configuration: cache-block sizes, counts, totals
    always_ff @(posedge clk)
    begin
        for (int d = 0; d < 4; d++) begin
            ext_reg[d]  <= ext_cl[d];
            tot_reg[d]  <= TOT_W'(TOT_W'(procs_cl[d]) * TOT_W'(ext_cl[d]));
            nblk_reg[d] <= nblk_div[d][2*PROC_W-1:PROC_W];
        end
        for (int d = 1; d < 4; d++) begin
            if (ext_cl[d][1:0] == 2'b00) begin
                cb_reg[d]  <= CB_W'(4);
                cbc_reg[d] <= ext_cl[d] >> 2;
            end else if (ext_cl[d] == EXT_W'(EXT_W'(div3(ext_cl[d])) * EXT_W'(3))) begin
                cb_reg[d]  <= CB_W'(3);
                cbc_reg[d] <= EXT_W'(div3(ext_cl[d]));
            end else if (!ext_cl[d][0]) begin
                cb_reg[d]  <= CB_W'(2);
                cbc_reg[d] <= ext_cl[d] >> 1;
            end else begin
                cb_reg[d]  <= CB_W'(1);
                cbc_reg[d] <= ext_cl[d];
            end
        end
        e01_reg <= 14'(14'(ext_cl[0]) * 14'(ext_cl[1]));
        e23_reg <= 14'(14'(ext_cl[2]) * 14'(ext_cl[3]));
        cbp_reg <= 7'(7'(cb_reg[1]) * 7'(cb_reg[2]) * 7'(cb_reg[3]));
    end

    // derived configuration: half volume and cache-block volume
    assign vol_full = 28'(e01_reg) * 28'(e23_reg);
    always_ff @(posedge clk)
    begin
        vol_half_reg <= vol_full[SITE_W:1];
        cb_vol_reg   <= 13'(13'(ext_reg[0]) * 13'(cbp_reg));
    end

    // table rebuild walk over one cache block
    assign walk_par  = wa_reg[0] ^ wb_reg[0] ^ wc_reg[0] ^ we_reg[0];
    assign walk_last = ({1'b0, wa_reg} == ext_reg[0] - EXT_W'(1))
                    && ({1'b0, wb_reg} == cb_reg[1] - CB_W'(1))
                    && ({1'b0, wc_reg} == cb_reg[2] - CB_W'(1))
                    && ({1'b0, we_reg} == cb_reg[3] - CB_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_SETTLE;
            settle_reg <= '0;
            wa_reg     <= '0;
            wb_reg     <= '0;
            wc_reg     <= '0;
            we_reg     <= '0;
            wpos_reg   <= '0;
            even_reg   <= '0;
            odd_reg    <= '0;
        end else if (cfg_wr) begin
            state_reg  <= ST_SETTLE;
            settle_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_SETTLE: begin
                    settle_reg <= settle_reg + 2'd1;
                    if (settle_reg == 2'd2) begin
                        state_reg <= ST_WALK;
                        wa_reg    <= '0;
                        wb_reg    <= '0;
                        wc_reg    <= '0;
                        we_reg    <= '0;
                        wpos_reg  <= '0;
                        even_reg  <= '0;
                        odd_reg   <= '0;
                    end
                end
                ST_WALK: begin
                    wpos_reg <= wpos_reg + POS_W'(1);
                    if (walk_par)
                        odd_reg <= odd_reg + TAB_W'(1);
                    else
                        even_reg <= even_reg + TAB_W'(1);
                    if ({1'b0, we_reg} != cb_reg[3] - CB_W'(1)) begin
                        we_reg <= we_reg + 2'd1;
                    end else begin
                        we_reg <= '0;
                        if ({1'b0, wc_reg} != cb_reg[2] - CB_W'(1)) begin
                            wc_reg <= wc_reg + 2'd1;
                        end else begin
                            wc_reg <= '0;
                            if ({1'b0, wb_reg} != cb_reg[1] - CB_W'(1)) begin
                                wb_reg <= wb_reg + 2'd1;
                            end else begin
                                wb_reg <= '0;
                                wa_reg <= wa_reg + Y_W'(1);
                            end
                        end
                    end
                    if (walk_last)
                        state_reg <= ST_RUN;
                end
                ST_RUN: ;
                default: state_reg <= ST_SETTLE;
            endcase
        end
    end

    // rank table
    lsri_ram #(
        .WIDTH (TAB_W),
        .DEPTH (RANK_TABLE_DEPTH)
    ) u_rank_ram (
        .clk     (clk),
        .wr_en   ((state_reg == ST_WALK) && ({1'b0, wpos_reg} < DEPTH_LIM)),
        .wr_addr (wpos_reg[ADDR_W-1:0]),
        .wr_data (walk_par ? odd_reg : even_reg),
        .rd_en   (adv),
        .rd_addr (s11_pos_reg[ADDR_W-1:0]),
        .rd_data (tab_rd)
    );

    // valid bits travel with the items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k <= LAST; k++)
                vld_reg[k] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid && run;
            for (int k = 1; k <= LAST; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // stage 8 per-dimension cache-block split and process block split
    always_comb
    begin
        for (int d = 1; d < 4; d++) begin
            case (cb_reg[d])
                CB_W'(4): begin
                    s8_yq_next[d] = s7_y_reg[d] >> 2;
                    s8_yr_next[d] = s7_y_reg[d][1:0];
                end
                CB_W'(3): begin
                    s8_yq_next[d] = div3({1'b0, s7_y_reg[d]});
                    s8_yr_next[d] = 2'(s7_y_reg[d] - Y_W'(s8_yq_next[d] * Y_W'(3)));
                end
                CB_W'(2): begin
                    s8_yq_next[d] = s7_y_reg[d] >> 1;
                    s8_yr_next[d] = {1'b0, s7_y_reg[d][0]};
                end
                default: begin
                    s8_yq_next[d] = s7_y_reg[d];
                    s8_yr_next[d] = 2'd0;
                end
            endcase
        end
        for (int d = 0; d < 4; d++)
            s8_div_next[d] = div_small(PROC_W'(s7_p_reg[d]), PROC_W'(PB[d]));
    end

    assign tab_sel = s12_inr_reg ? tab_rd : '0;

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv) begin
            // accept: magnitude and sign
            for (int d = 0; d < 4; d++) begin
                div_rem_reg[0][d] <= '0;
                div_neg_reg[0][d] <= coord_in[d][COORD_W-1];
                div_dvd_reg[0][d] <= 20'(coord_in[d][COORD_W-1]
                                         ? COORD_W'(~coord_in[d] + 1'b1)
                                         : COORD_W'(coord_in[d]));
            end
            // remainder by total extent, four bits a stage
            for (int k = 1; k <= DIV_STAGES; k++) begin
                for (int d = 0; d < 4; d++) begin
                    div_rem_reg[k][d] <= mod_step4(div_rem_reg[k-1][d],
                                                   div_dvd_reg[k-1][d][19:16], tot_reg[d]);
                    div_dvd_reg[k][d] <= div_dvd_reg[k-1][d] << 4;
                    div_neg_reg[k][d] <= div_neg_reg[k-1][d];
                end
            end
            // periodic wrap of negative coordinates
            for (int d = 0; d < 4; d++) begin
                if (div_neg_reg[DIV_STAGES][d] && (div_rem_reg[DIV_STAGES][d] != '0))
                    s6_w_reg[d] <= tot_reg[d] - div_rem_reg[DIV_STAGES][d];
                else
                    s6_w_reg[d] <= div_rem_reg[DIV_STAGES][d];
            end
            // process coordinate and local coordinate
            for (int d = 0; d < 4; d++)
                {s7_p_reg[d], s7_y_reg[d]} <= div_ext(s6_w_reg[d], ext_reg[d]);
            // cache-block split, process block split, parity
            for (int d = 1; d < 4; d++) begin
                s8_yq_reg[d] <= s8_yq_next[d];
                s8_yr_reg[d] <= s8_yr_next[d];
            end
            for (int d = 0; d < 4; d++) begin
                s8_nb_reg[d] <= s8_div_next[d][PROC_W+P_W-1:PROC_W];
                s8_np_reg[d] <= s8_div_next[d][P_W-1:0];
            end
            s8_y0_reg  <= s7_y_reg[0];
            s8_par_reg <= s7_y_reg[0][0] ^ s7_y_reg[1][0] ^ s7_y_reg[2][0] ^ s7_y_reg[3][0];
            // mixed-radix accumulation, first step
            s9_posa_reg  <= 8'(s8_yr_reg[1]) + 8'(cb_reg[1]) * 8'(s8_y0_reg);
            s9_cella_reg <= 12'(s8_yq_reg[2]) + 12'(cbc_reg[2]) * 12'(s8_yq_reg[1]);
            s9_br_reg    <= RANK_W'(s8_nb_reg[0]) * RANK_W'(nblk_reg[1])
                          + RANK_W'(s8_nb_reg[1]);
            s9_ir_reg    <= RANK_W'(s8_np_reg[0]) * RANK_W'(PB[1]) + RANK_W'(s8_np_reg[1]);
            s9_yr2_reg   <= s8_yr_reg[2];
            s9_yr3_reg   <= s8_yr_reg[3];
            s9_yq3_reg   <= s8_yq_reg[3];
            s9_nb2_reg   <= s8_nb_reg[2];
            s9_nb3_reg   <= s8_nb_reg[3];
            s9_np2_reg   <= s8_np_reg[2];
            s9_np3_reg   <= s8_np_reg[3];
            s9_par_reg   <= s8_par_reg;
            // second step
            s10_posb_reg <= 10'(s9_yr2_reg) + 10'(cb_reg[2]) * 10'(s9_posa_reg);
            s10_cell_reg <= CELL_W'(s9_yq3_reg) + CELL_W'(cbc_reg[3]) * CELL_W'(s9_cella_reg);
            s10_br_reg   <= s9_br_reg * RANK_W'(nblk_reg[2]) + RANK_W'(s9_nb2_reg);
            s10_ir_reg   <= s9_ir_reg * RANK_W'(PB[2]) + RANK_W'(s9_np2_reg);
            s10_yr3_reg  <= s9_yr3_reg;
            s10_nb3_reg  <= s9_nb3_reg;
            s10_np3_reg  <= s9_np3_reg;
            s10_par_reg  <= s9_par_reg;
            // third step, table position
            s11_pos_reg  <= POS_W'(s10_yr3_reg) + POS_W'(cb_reg[3]) * POS_W'(s10_posb_reg);
            s11_cell_reg <= s10_cell_reg;
            s11_br_reg   <= s10_br_reg * RANK_W'(nblk_reg[3]) + RANK_W'(s10_nb3_reg);
            s11_ir_reg   <= s10_ir_reg * RANK_W'(PB[3]) + RANK_W'(s10_np3_reg);
            s11_par_reg  <= s10_par_reg;
            // table read in flight, block offset and rank
            s12_inr_reg  <= ({1'b0, s11_pos_reg} < DEPTH_LIM);
            s12_cbp_reg  <= 25'(cb_vol_reg) * 25'(s11_cell_reg);
            s12_rank_reg <= s11_ir_reg + s11_br_reg * BLK_VOL;
            s12_par_reg  <= s11_par_reg;
            // result
            rank_out_reg <= s12_rank_reg;
            site_out_reg <= SITE_W'(tab_sel)
                          + (s12_par_reg ? vol_half_reg : '0)
                          + s12_cbp_reg[SITE_W:1];
        end
    end

    assign out_valid  = vld_reg[LAST];
    assign owner_rank = rank_out_reg;
    assign local_site = site_out_reg;

endmodule

### sv/lsri_checker.sv
// Port-level checker of the lattice site locator and its bind
`include "lattice_site_to_rank_and_index_top_macros.svh"

module lsri_props
    import lsri_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [CFG_IDX_W-1:0]      cfg_index,
    input logic [CFG_DATA_W-1:0]     cfg_data,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic signed [COORD_W-1:0] coord_t,
    input logic signed [COORD_W-1:0] coord_x,
    input logic signed [COORD_W-1:0] coord_y,
    input logic signed [COORD_W-1:0] coord_z,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [RANK_W-1:0]         owner_rank,
    input logic [SITE_W-1:0]         local_site
);

    // a register write starts a table rebuild, so no item is taken next
    `LSRI_ASSERT_NEXT(a_cfg_rebuild, cfg_valid && cfg_ready, in_stall, "item taken during rebuild")

    // a held result freezes the pipeline back to the input
    `LSRI_ASSERT_SAME(a_stall_back, out_valid && out_stall, in_stall, "input open while frozen")

    // a stalled result stays put
    `LSRI_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(owner_rank) && $stable(local_site), "stalled result changed")

endmodule

bind lattice_site_to_rank_and_index_top lsri_props u_lsri_props (.*);
